[design/tws_pkg.sv]
`default_nettype none
package tws_pkg;

  localparam int TEX_SIZE_DEF   = 64;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_SCREEN_DEF = 4096;
  localparam int NUM_TEXTURES   = 8;
  localparam int TEX_SEL_W      = 3;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_W          = 13;
  localparam int CFG_INDEX_W    = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0]       SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0]       SCREEN_HEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_PIXEL = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_PIXEL = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] column_x;
    logic [11:0] draw_start;
    logic [12:0] draw_end;
    logic [15:0] line_height;
    logic [7:0]  cell_code;
    logic        side;
    logic        ray_x_negative;
    logic        ray_y_negative;
    logic [5:0]  tex_column;
    logic [14:0] texel_addr;
    logic [31:0] texel_value;
  } tws_in_t;

  typedef struct packed {
    logic [23:0] pixel_index;
    logic [31:0] pixel_color;
    logic        last_pixel;
  } tws_out_t;

  typedef struct packed {
    op_t                  op;
    logic [14:0]          addr;
    logic [31:0]          value;
    logic [15:0]          offset;
    logic [15:0]          line_height;
    logic [11:0]          draw_start;
    logic [12:0]          end_row;
    logic [11:0]          column;
    logic [TEX_SEL_W-1:0] tex_sel;
    logic [5:0]           tex_column;
  } tws_entry_t;

  typedef struct packed {
    logic idle;
    logic start_pop;
    logic pixel_issue;
  } tws_status_t;

endpackage
`default_nettype wire

[design/textured_wall_column_sampler_unit.sv]
// Textured wall column sampler.
// Input channel item_valid/item_ready carries one command per transfer:
// load texel, start span, or next pixel. Results leave on result_valid/
// result_ready, one per drawn pixel, with the final pixel of a span flagged.
// Screen width and height are written on cfg_write/cfg_index/cfg_data; the
// user must write them only while the block is idle; it is not enforced.
// Items enter a four-entry queue; the execution side pulls from it. Pixels
// stream at one per cycle while the receiver is ready and no span start is
// in progress; each result passes through a queue entry and then the result
// register. A span start holds the execution side while the restoring
// divider for the step retires one quotient bit per cycle and then the
// start-position multiply runs; a zero line height skips the divider and
// goes straight to the multiply.
// Input keeps flowing into the queue meanwhile until it fills.
// When the receiver stalls, the result register holds and pixels wait in the
// queue; a load or start at its head proceeds, but none passes a waiting
// pixel. Reset empties the queue, clears the span state and restores 640 by
// 480; textures are undefined until written, and no clearing pass runs.
`default_nettype none
module textured_wall_column_sampler_unit import tws_pkg::*; #(
  parameter int TEX_SIZE   = TEX_SIZE_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_SCREEN = MAX_SCREEN_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire tws_in_t                item,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output tws_out_t                    result,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  localparam int QLW = $clog2(QUEUE_DEPTH + 1);

  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;
  logic             push_valid;
  logic             push_ready;
  tws_entry_t       push_entry;
  logic             head_valid;
  logic             head_ready;
  tws_entry_t       head;
  logic [QLW-1:0]   q_level;
  tws_status_t      status;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_write) begin
      if (cfg_index == REG_SCREEN_WIDTH) begin
        screen_width <= cfg_data;
      end else if (cfg_index == REG_SCREEN_HEIGHT) begin
        screen_height <= cfg_data;
      end
    end
  end

  tws_front #(
    .TEX_SIZE   (TEX_SIZE),
    .MAX_SCREEN (MAX_SCREEN)
  ) u_front (
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .screen_height (screen_height),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  tws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_entry  (head),
    .level      (q_level)
  );

  tws_back #(
    .TEX_SIZE  (TEX_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_ready   (head_ready),
    .head         (head),
    .screen_width (screen_width),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .status       (status)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    status.start_pop |=> !status.idle)
    else $error("span start did not occupy the execution side");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(status.pixel_issue))
    else $error("result appeared without a pixel issue");

  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    q_level <= QLW'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

  a_no_issue_busy: assert property (@(posedge clk) disable iff (rst)
    !status.idle |-> !status.pixel_issue)
    else $error("pixel issued while span start in progress");

endmodule
`default_nettype wire

[design/tws_front.sv]
`default_nettype none
module tws_front import tws_pkg::*; #(
  parameter int TEX_SIZE   = TEX_SIZE_DEF,
  parameter int MAX_SCREEN = MAX_SCREEN_DEF
) (
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire tws_in_t          item,
  input  wire logic [CFG_W-1:0] screen_height,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output tws_entry_t            push_entry
);

  localparam int STORE_DEPTH = NUM_TEXTURES * TEX_SIZE * TEX_SIZE;

  localparam logic [7:0] CODE_ONE   = 8'h31;
  localparam logic [7:0] CODE_TWO   = 8'h32;
  localparam logic [7:0] CODE_THREE = 8'h33;
  localparam logic [7:0] CODE_SEVEN = 8'h37;
  localparam logic [7:0] CODE_EIGHT = 8'h38;
  localparam logic [7:0] CODE_NINE  = 8'h39;

  localparam logic [TEX_SEL_W-1:0] TEX_X_NEG   = 3'd0;
  localparam logic [TEX_SEL_W-1:0] TEX_X_POS   = 3'd1;
  localparam logic [TEX_SEL_W-1:0] TEX_Y_NEG   = 3'd2;
  localparam logic [TEX_SEL_W-1:0] TEX_Y_POS   = 3'd3;
  localparam logic [TEX_SEL_W-1:0] TEX_CODE_2  = 3'd4;
  localparam logic [TEX_SEL_W-1:0] TEX_CODE_7  = 3'd5;
  localparam logic [TEX_SEL_W-1:0] TEX_CODE_8  = 3'd6;
  localparam logic [TEX_SEL_W-1:0] TEX_CODE_9  = 3'd7;
  localparam logic [TEX_SEL_W-1:0] TEX_DEFAULT = 3'd0;

  logic signed [17:0]   offset_full;
  logic [TEX_SEL_W-1:0] tex_sel;
  logic                 keep;
  op_t                  op;

  always_comb begin
    unique case (item.cell_code)
      CODE_ONE: begin
        if (item.side) begin
          tex_sel = item.ray_y_negative ? TEX_Y_NEG : TEX_Y_POS;
        end else begin
          tex_sel = item.ray_x_negative ? TEX_X_NEG : TEX_X_POS;
        end
      end
      CODE_THREE: tex_sel = TEX_X_NEG;
      CODE_TWO:   tex_sel = TEX_CODE_2;
      CODE_SEVEN: tex_sel = TEX_CODE_7;
      CODE_EIGHT: tex_sel = TEX_CODE_8;
      CODE_NINE:  tex_sel = TEX_CODE_9;
      default:    tex_sel = TEX_DEFAULT;
    endcase
  end

  always_comb begin
    unique case (cmd_t'(item.cmd))
      CMD_LOAD: begin
        op   = OP_LOAD;
        keep = {17'd0, item.texel_addr} < 32'(STORE_DEPTH);
      end
      CMD_START: begin
        op   = OP_START;
        keep = 1'b1;
      end
      CMD_PIXEL: begin
        op   = OP_PIXEL;
        keep = 1'b1;
      end
      default: begin
        op   = OP_PIXEL;
        keep = 1'b0;
      end
    endcase
  end

  assign offset_full = $signed({6'd0, item.draw_start})
                     - $signed({6'd0, screen_height[CFG_W-1:1]})
                     + $signed({3'd0, item.line_height[15:1]});

  always_comb begin
    push_entry.op          = op;
    push_entry.addr        = item.texel_addr;
    push_entry.value       = item.texel_value;
    push_entry.offset      = (offset_full > 18'sd0) ? offset_full[15:0] : 16'd0;
    push_entry.line_height = item.line_height;
    push_entry.draw_start  = item.draw_start;
    push_entry.end_row     = (item.draw_end > 13'(MAX_SCREEN)) ? 13'(MAX_SCREEN)
                                                               : item.draw_end;
    push_entry.column      = item.column_x;
    push_entry.tex_sel     = tex_sel;
    push_entry.tex_column  = item.tex_column;
  end

  // drop ignored commands and out-of-range texel writes on transfer
  assign item_ready = push_ready;
  assign push_valid = item_valid && keep;

endmodule
`default_nettype wire

[design/tws_queue.sv]
`default_nettype none
module tws_queue import tws_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push_valid,
  output logic                          push_ready,
  input  wire tws_entry_t               push_entry,
  output logic                          pop_valid,
  input  wire logic                     pop_ready,
  output tws_entry_t                    pop_entry,
  output logic [$clog2(DEPTH+1)-1:0]    level
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  tws_entry_t     entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [LW-1:0]  count;
  logic           push;
  logic           pop;

  assign push_ready = count != LW'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = entries[rd_ptr];
  assign level      = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

[design/tws_back.sv]
`default_nettype none
module tws_back import tws_pkg::*; #(
  parameter int TEX_SIZE  = TEX_SIZE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  output logic                  head_ready,
  input  wire tws_entry_t       head,
  input  wire logic [CFG_W-1:0] screen_width,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output tws_out_t              result,
  output tws_status_t           status
);

  localparam int TSB   = $clog2(TEX_SIZE);
  localparam int AW    = TEX_SEL_W + 2 * TSB;
  localparam int DEPTH = 1 << AW;
  localparam int NUMW  = TSB + FRAC_BITS + 1;
  localparam int CW    = $clog2(NUMW);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_MUL  = 3'b100
  } state_t;

  state_t               state;
  logic [31:0]          tex_position;
  logic [31:0]          tex_step;
  logic [12:0]          current_row;
  logic [12:0]          end_row;
  logic [11:0]          span_column;
  logic [TEX_SEL_W-1:0] texture_choice;
  logic [5:0]           span_tex_column;

  logic [15:0]          divisor;
  logic [15:0]          rem;
  logic [NUMW-1:0]      quot;
  logic [CW-1:0]        cnt;
  logic                 div_zero;
  logic [15:0]          offset_q;

  logic [31:0]          store [DEPTH];
  logic [31:0]          rd_data;
  logic [23:0]          pix_index_q;
  logic                 last_q;

  logic [32:0]          pos_sum;
  logic [31:0]          pos_next;
  logic                 span_done;
  logic                 out_free;
  logic                 pop;
  logic                 issue;
  logic                 start_pop;
  logic                 mem_we;
  logic [13:0]          row_inc;
  logic [25:0]          pix_mul;
  logic [26:0]          pix_sum;
  logic [AW-1:0]        raddr;
  logic [16:0]          rem_shift;
  logic [16:0]          rem_diff;
  logic                 ge;
  logic [15:0]          rem_next;
  logic [63:0]          q_wide;
  logic [31:0]          step_v;
  logic [47:0]          prod;

  always_comb begin
    pos_sum   = {1'b0, tex_position} + {1'b0, tex_step};
    pos_next  = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
    span_done = current_row >= end_row;
    out_free  = !result_valid || result_ready;
    head_ready = (state == ST_IDLE) && (head.op != OP_PIXEL || span_done || out_free);
    pop       = head_valid && head_ready;
    issue     = pop && head.op == OP_PIXEL && !span_done;
    start_pop = pop && head.op == OP_START;
    mem_we    = pop && head.op == OP_LOAD;
    row_inc   = {1'b0, current_row} + 14'd1;
    pix_mul   = current_row * screen_width;
    pix_sum   = {1'b0, pix_mul} + {15'd0, span_column};
    raddr     = {texture_choice, pos_next[FRAC_BITS +: TSB], TSB'(span_tex_column)};

    rem_shift = {rem, cnt == CW'(NUMW - 1)};
    rem_diff  = rem_shift - {1'b0, divisor};
    ge        = rem_shift >= {1'b0, divisor};
    rem_next  = ge ? rem_diff[15:0] : rem_shift[15:0];

    q_wide    = 64'(quot);
    if (div_zero || q_wide > 64'h0000_0000_FFFF_FFFF) begin
      step_v = 32'hFFFF_FFFF;
    end else begin
      step_v = q_wide[31:0];
    end
    prod      = offset_q * step_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      tex_position    <= '0;
      tex_step        <= '0;
      current_row     <= '0;
      end_row         <= '0;
      span_column     <= '0;
      texture_choice  <= '0;
      span_tex_column <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (issue) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start_pop) begin
            current_row     <= {1'b0, head.draw_start};
            end_row         <= head.end_row;
            span_column     <= head.column;
            texture_choice  <= head.tex_sel;
            span_tex_column <= head.tex_column;
            state           <= (head.line_height == 16'd0) ? ST_MUL : ST_DIV;
          end else if (issue) begin
            tex_position <= pos_next;
            current_row  <= row_inc[12:0];
          end
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          tex_step     <= step_v;
          tex_position <= (prod > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start_pop) begin
      divisor  <= head.line_height;
      rem      <= '0;
      quot     <= '0;
      cnt      <= CW'(NUMW - 1);
      div_zero <= head.line_height == 16'd0;
      offset_q <= head.offset;
    end else if (state == ST_DIV) begin
      rem  <= rem_next;
      quot <= {quot[NUMW-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
    if (issue) begin
      pix_index_q <= pix_sum[23:0];
      last_q      <= row_inc >= {1'b0, end_row};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[AW'(head.addr)] <= head.value;
    end
    if (issue) begin
      rd_data <= store[raddr];
    end
  end

  always_comb begin
    result.pixel_index = pix_index_q;
    result.pixel_color = rd_data;
    result.last_pixel  = last_q;
    status.idle        = state == ST_IDLE;
    status.start_pop   = start_pop;
    status.pixel_issue = issue;
  end

endmodule
`default_nettype wire

[bench/tb.sv]
`default_nettype none
module tb import tws_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 500000;
  localparam int TEXELS = NUM_TEXTURES * TEX_SIZE_DEF * TEX_SIZE_DEF;
  localparam int PHASE_ITEMS = 240;
  localparam int DRAIN_CYCLES = 100;

  localparam logic [7:0] CODE_FACED = "1";
  localparam logic [7:0] CODE_TWO   = "2";
  localparam logic [7:0] CODE_THREE = "3";
  localparam logic [7:0] CODE_SEVEN = "7";
  localparam logic [7:0] CODE_EIGHT = "8";
  localparam logic [7:0] CODE_NINE  = "9";

  localparam logic [2:0] TEX_NORTH = 3'd0;
  localparam logic [2:0] TEX_XPOS  = 3'd1;
  localparam logic [2:0] TEX_YNEG  = 3'd2;
  localparam logic [2:0] TEX_YPOS  = 3'd3;
  localparam logic [2:0] TEX_CODE2 = 3'd4;
  localparam logic [2:0] TEX_CODE7 = 3'd5;
  localparam logic [2:0] TEX_CODE8 = 3'd6;
  localparam logic [2:0] TEX_CODE9 = 3'd7;

  class wall_span_tracker;
    logic [31:0] texels [TEXELS];
    bit written [TEXELS];
    logic [31:0] position, pos_step;
    logic [12:0] cur_row, end_row;
    logic [11:0] column;
    logic [2:0]  choice;
    logic [5:0]  tcol;
    logic [12:0] width, height;
    tws_out_t due_pixels[$];
    int mismatches;

    function new();
      position = '0;
      pos_step = '0;
      cur_row = '0;
      end_row = '0;
      column = '0;
      choice = '0;
      tcol = '0;
      width = SCREEN_WIDTH_RST;
      height = SCREEN_HEIGHT_RST;
      mismatches = 0;
    endfunction

    function logic [31:0] sat32(longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function logic [31:0] advance(logic [31:0] p);
      longint unsigned v;
      v = p;
      v = v + pos_step;
      return sat32(v);
    endfunction

    function int unsigned texel_index(logic [31:0] p);
      int unsigned row;
      row = (p >> FRAC_BITS_DEF) & (TEX_SIZE_DEF - 1);
      return choice * TEX_SIZE_DEF * TEX_SIZE_DEF + row * TEX_SIZE_DEF
             + (tcol & (TEX_SIZE_DEF - 1));
    endfunction

    function bit texel_missing(output int unsigned addr);
      addr = 0;
      if (cur_row >= end_row) return 1'b0;
      addr = texel_index(advance(position));
      return !written[addr];
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_SCREEN_WIDTH) width = data;
      else if (idx == REG_SCREEN_HEIGHT) height = data;
    endfunction

    function void take_item(tws_in_t it);
      longint unsigned wide;
      longint offset;
      tws_out_t px;
      case (it.cmd)
        CMD_LOAD: begin
          texels[it.texel_addr] = it.texel_value;
          written[it.texel_addr] = 1'b1;
        end
        CMD_START: begin
          if (it.line_height == 0) begin
            pos_step = 32'hFFFF_FFFF;
          end else begin
            wide = longint'(TEX_SIZE_DEF) << FRAC_BITS_DEF;
            pos_step = sat32(wide / it.line_height);
          end
          offset = longint'(it.draw_start) - longint'(height / 2)
                   + longint'(it.line_height / 2);
          if (offset <= 0) begin
            position = '0;
          end else begin
            wide = offset;
            wide = wide * pos_step;
            position = sat32(wide);
          end
          cur_row = it.draw_start;
          end_row = (it.draw_end > MAX_SCREEN_DEF) ? 13'(MAX_SCREEN_DEF) : it.draw_end;
          column = it.column_x;
          tcol = it.tex_column;
          case (it.cell_code)
            CODE_FACED: begin
              if (it.side) choice = it.ray_y_negative ? TEX_YNEG : TEX_YPOS;
              else choice = it.ray_x_negative ? TEX_NORTH : TEX_XPOS;
            end
            CODE_THREE: choice = TEX_NORTH;
            CODE_TWO:   choice = TEX_CODE2;
            CODE_SEVEN: choice = TEX_CODE7;
            CODE_EIGHT: choice = TEX_CODE8;
            CODE_NINE:  choice = TEX_CODE9;
            default:    choice = TEX_NORTH;
          endcase
        end
        CMD_PIXEL: begin
          if (cur_row < end_row) begin
            position = advance(position);
            wide = cur_row;
            wide = wide * width + column;
            px.pixel_index = wide[23:0];
            px.pixel_color = texels[texel_index(position)];
            px.last_pixel = (cur_row + 14'd1 >= end_row);
            due_pixels.push_back(px);
            cur_row = cur_row + 13'd1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(tws_out_t got);
      tws_out_t want;
      if (due_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = due_pixels.pop_front();
      if (got.pixel_index !== want.pixel_index) begin
        $display("%0t: pixel_index expected %h actual %h", $time,
                 want.pixel_index, got.pixel_index);
        mismatches++;
      end
      if (got.pixel_color !== want.pixel_color) begin
        $display("%0t: pixel_color expected %h actual %h", $time,
                 want.pixel_color, got.pixel_color);
        mismatches++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $display("%0t: last_pixel expected %b actual %b", $time,
                 want.last_pixel, got.last_pixel);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  tws_in_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  tws_out_t result;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  wall_span_tracker tracker = new();
  int cycles = 0;
  int sent_items = 0;
  int stall_left = 0;
  bit quiet = 1'b0;
  bit gap_mode = 1'b1;

  textured_wall_column_sampler_unit u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) tracker.take_item(item);
    if (!rst && result_valid && result_ready) tracker.check_pixel(result);
  end

  always @(negedge clk) begin
    if (quiet) begin
      result_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      result_ready <= 1'b0;
      stall_left = $urandom_range(1, 14);
    end else begin
      result_ready <= 1'b1;
      stall_left = $urandom_range(1, 30);
    end
  end

  function automatic tws_in_t rand_item();
    tws_in_t it;
    it.cmd = $urandom;
    it.column_x = $urandom;
    it.draw_start = $urandom;
    it.draw_end = $urandom;
    it.line_height = $urandom;
    it.cell_code = $urandom;
    it.side = $urandom;
    it.ray_x_negative = $urandom;
    it.ray_y_negative = $urandom;
    it.tex_column = $urandom;
    it.texel_addr = $urandom;
    it.texel_value = $urandom;
    return it;
  endfunction

  // entered and left on a falling edge
  task automatic send(tws_in_t it);
    if (!quiet && gap_mode && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    if (it.cmd != CMD_NONE) sent_items++;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic load_texel(logic [14:0] addr, logic [31:0] value);
    tws_in_t it;
    it = rand_item();
    it.cmd = CMD_LOAD;
    it.texel_addr = addr;
    it.texel_value = value;
    send(it);
  endtask

  // fill the texel the next pixel reads if it was never written
  task automatic send_pixel();
    tws_in_t it;
    int unsigned addr;
    if (tracker.texel_missing(addr)) load_texel(addr[14:0], $urandom);
    it = rand_item();
    it.cmd = CMD_PIXEL;
    send(it);
  endtask

  task automatic start_span(logic [11:0] ds, logic [12:0] de, logic [15:0] lh,
                            logic [7:0] code, logic sd, logic xn, logic yn,
                            logic [5:0] tc);
    tws_in_t it;
    it = rand_item();
    it.cmd = CMD_START;
    it.draw_start = ds;
    it.draw_end = de;
    it.line_height = lh;
    it.cell_code = code;
    it.side = sd;
    it.ray_x_negative = xn;
    it.ray_y_negative = yn;
    it.tex_column = tc;
    send(it);
  endtask

  task automatic hold_until_drained();
    item_valid <= 1'b0;
    do @(negedge clk); while (tracker.due_pixels.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    tracker.set_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_span();
    logic [11:0] ds;
    logic [12:0] de;
    logic [15:0] lh;
    logic [7:0] code;
    int kind, span_len, n_px;
    gap_mode = ($urandom_range(0, 2) != 0);
    kind = $urandom_range(0, 9);
    ds = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 600));
    de = ds + $urandom_range(1, 12);
    if (kind == 0) begin
      de = $urandom_range(0, ds);
    end else if (kind == 1) begin
      ds = $urandom_range(4080, 4095);
      de = $urandom_range(4097, 8191);
    end
    case ($urandom_range(0, 15))
      0:       lh = 16'd0;
      1, 2:    lh = $urandom;
      default: lh = $urandom_range(1, 256);
    endcase
    case ($urandom_range(0, 11))
      0, 1, 2: code = CODE_FACED;
      3:       code = CODE_TWO;
      4:       code = CODE_THREE;
      5:       code = CODE_SEVEN;
      6:       code = CODE_EIGHT;
      7:       code = CODE_NINE;
      default: code = $urandom;
    endcase
    start_span(ds, de, lh, code, $urandom, $urandom, $urandom, $urandom);
    span_len = ((de > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : int'(de)) - int'(ds);
    if (span_len < 0) span_len = 0;
    n_px = span_len + $urandom_range(0, 2);
    if ($urandom_range(0, 5) == 0) n_px = $urandom_range(0, n_px);
    repeat (n_px) begin
      if ($urandom_range(0, 15) == 0) load_texel($urandom, $urandom);
      send_pixel();
    end
  endtask

  initial begin
    tws_in_t it;
    logic [CFG_W-1:0] widths [5];
    logic [CFG_W-1:0] heights [5];
    int target;
    bit pressed;
    widths = '{13'd640, 13'd1, 13'd4096, 13'd8191, 13'd0};
    heights = '{13'd480, 13'd1, 13'd4096, 13'd8191, 13'd0};
    widths[4] = $urandom_range(2, 4095);
    heights[4] = $urandom_range(2, 4095);

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    load_texel(15'd0, 32'd0);
    load_texel(15'h7FFF, 32'hFFFF_FFFF);
    send_pixel();
    it = rand_item();
    it.cmd = CMD_NONE;
    send(it);
    // zero height: saturated step, then saturated advance
    start_span(12'd0, 13'd2, 16'd0, CODE_FACED, 1'b0, 1'b1, 1'b0, 6'd63);
    send_pixel();
    send_pixel();
    // end clamped to the screen, start position saturated
    start_span(12'd4095, 13'd8191, 16'd1, CODE_NINE, 1'b0, 1'b0, 1'b0, 6'd0);
    send_pixel();
    send_pixel();
    start_span(12'd0, 13'd1, 16'hFFFF, CODE_TWO, 1'b1, 1'b1, 1'b1, 6'd21);
    send_pixel();
    // negative start offset
    start_span(12'd0, 13'd1, 16'd2, CODE_EIGHT, 1'b0, 1'b0, 1'b0, 6'd5);
    send_pixel();
    start_span(12'd300, 13'd301, 16'd64, CODE_THREE, 1'b1, 1'b0, 1'b1, 6'd40);
    send_pixel();
    start_span(12'd100, 13'd101, 16'd100, CODE_SEVEN, 1'b0, 1'b1, 1'b1, 6'd9);
    send_pixel();
    start_span(12'd240, 13'd241, 16'd32, CODE_FACED, 1'b1, 1'b0, 1'b0, 6'd17);
    send_pixel();
    start_span(12'd10, 13'd11, 16'd7, CODE_FACED, 1'b1, 1'b0, 1'b1, 6'd33);
    send_pixel();
    start_span(12'd10, 13'd11, 16'd7, CODE_FACED, 1'b0, 1'b0, 1'b0, 6'd2);
    send_pixel();
    start_span(12'd10, 13'd11, 16'd9, 8'hFF, 1'b0, 1'b1, 1'b0, 6'd50);
    send_pixel();

    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_reg(REG_SCREEN_WIDTH, widths[phase]);
        write_reg(REG_SCREEN_HEIGHT, heights[phase]);
      end
      target = sent_items + PHASE_ITEMS;
      pressed = 1'b0;
      while (sent_items < target) begin
        if (phase == 4 && sent_items >= target - 100) quiet = 1'b1;
        if (!pressed && sent_items >= target - PHASE_ITEMS / 2) begin
          hold_until_drained();
          pressed = 1'b1;
        end
        case ($urandom_range(0, 19))
          15, 16: load_texel($urandom, $urandom);
          17: begin
            it = rand_item();
            it.cmd = CMD_NONE;
            send(it);
          end
          18: send_pixel();
          19: begin
            it = rand_item();
            if (it.cmd == CMD_PIXEL) send_pixel();
            else send(it);
          end
          default: run_span();
        endcase
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.due_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
design/tws_pkg.sv
design/tws_front.sv
design/tws_queue.sv
design/tws_back.sv
design/textured_wall_column_sampler_unit.sv
bench/tb.sv
